>>> hw/rtl/one_shot_timer_pool_core_defines.svh
// Assertion macros shared by the timer pool RTL.
`ifndef ONE_SHOT_TIMER_POOL_CORE_DEFINES_SVH
`define ONE_SHOT_TIMER_POOL_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define OSTP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define OSTP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/ostp_pkg.sv
// Shared types, command and status codes for the one-shot timer pool.
package ostp_pkg;

  localparam int unsigned TIMER_COUNT = 8;
  localparam int unsigned ID_W        = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned PERIOD_W    = 32;
  localparam int unsigned STATUS_W    = 2;
  // The slot field is three bits wide, so only the slots it can name can be claimed.
  localparam int unsigned ALLOC_LIMIT = (TIMER_COUNT < (1 << IDX_W)) ? TIMER_COUNT
                                                                     : (1 << IDX_W);

  localparam logic [CMD_W-1:0] CMD_TICK       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REGISTER   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_START      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_STOP       = 3'd3;
  localparam logic [CMD_W-1:0] CMD_UNREGISTER = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CHECK      = 3'd5;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNREG = 2'd2;

  // Command token that walks the chain of slot cells.
  typedef struct packed {
    logic                valid;
    logic [CMD_W-1:0]    cmd;
    logic [IDX_W-1:0]    idx;
    logic [PERIOD_W-1:0] period;
    logic                found;
    logic [IDX_W-1:0]    slot;
    logic [STATUS_W-1:0] status;
    logic                expired;
  } token_t;

  // One result item.
  typedef struct packed {
    logic [IDX_W-1:0]    slot;
    logic [STATUS_W-1:0] status;
    logic                expired;
  } result_t;

endpackage

>>> hw/rtl/ostp_cell.sv
// One timer slot: holds its state and applies the passing command token.
module ostp_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [ostp_pkg::ID_W-1:0]    cell_id,
  input  ostp_pkg::token_t             tok_in,
  output ostp_pkg::token_t             tok_out
);

  logic                            used_r, used_nxt;
  logic                            running_r, running_nxt;
  logic [ostp_pkg::PERIOD_W-1:0]   period_r, period_nxt;
  logic [ostp_pkg::PERIOD_W-1:0]   count_r, count_nxt;
  ostp_pkg::token_t                tok_out_r, tok_out_nxt;
  logic                            hit;
  logic                            alloc_ok;

  assign hit      = tok_in.valid && used_r && (32'(tok_in.idx) == 32'(cell_id));
  assign alloc_ok = 32'(cell_id) < ostp_pkg::ALLOC_LIMIT;

  always_comb begin
    used_nxt    = used_r;
    running_nxt = running_r;
    period_nxt  = period_r;
    count_nxt   = count_r;
    tok_out_nxt = tok_in;
    unique case (tok_in.cmd)
      ostp_pkg::CMD_TICK: begin
        if (tok_in.valid && running_r && (count_r != '1)) begin
          count_nxt = count_r + 1'b1;
        end
      end
      ostp_pkg::CMD_REGISTER: begin
        // The first free slot down the chain claims the request.
        if (tok_in.valid && !tok_in.found && !used_r && alloc_ok) begin
          used_nxt           = 1'b1;
          running_nxt        = 1'b0;
          period_nxt         = tok_in.period;
          count_nxt          = '0;
          tok_out_nxt.found  = 1'b1;
          tok_out_nxt.slot   = ostp_pkg::IDX_W'(32'(cell_id));
          tok_out_nxt.status = ostp_pkg::ST_DONE;
        end
      end
      ostp_pkg::CMD_START: begin
        if (hit) begin
          count_nxt          = '0;
          running_nxt        = 1'b1;
          tok_out_nxt.status = ostp_pkg::ST_DONE;
        end
      end
      ostp_pkg::CMD_STOP: begin
        if (hit) begin
          running_nxt        = 1'b0;
          tok_out_nxt.status = ostp_pkg::ST_DONE;
        end
      end
      ostp_pkg::CMD_UNREGISTER: begin
        if (hit) begin
          used_nxt           = 1'b0;
          running_nxt        = 1'b0;
          tok_out_nxt.status = ostp_pkg::ST_DONE;
        end
      end
      ostp_pkg::CMD_CHECK: begin
        if (hit) begin
          tok_out_nxt.status = ostp_pkg::ST_DONE;
          if (running_r && (count_r >= period_r)) begin
            running_nxt         = 1'b0;
            tok_out_nxt.expired = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r          <= 1'b0;
      running_r       <= 1'b0;
      tok_out_r.valid <= 1'b0;
    end else begin
      used_r    <= used_nxt;
      running_r <= running_nxt;
      tok_out_r <= tok_out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    period_r <= period_nxt;
    count_r  <= count_nxt;
  end

  assign tok_out = tok_out_r;

endmodule

>>> hw/rtl/one_shot_timer_pool_core.sv
// Top level of the one-shot timer pool: command entry, cell chain and result buffer.
// Each item passes the entry register and then every slot cell before it reaches the output.
// Only one item is in the chain at a time: a new item is taken only after the last one left it.
// A finished result may wait in a two-entry output buffer while the next item is taken.
// Reset (rst_n low, synchronous) frees and stops every slot and empties the chain and buffer.
// Period and count storage is not reset; register writes it before any command reads it.
`include "one_shot_timer_pool_core_defines.svh"

module one_shot_timer_pool_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ostp_pkg::CMD_W-1:0]          in_command,
  input  logic [ostp_pkg::IDX_W-1:0]          in_timer_index,
  input  logic [ostp_pkg::PERIOD_W-1:0]       in_period,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ostp_pkg::IDX_W-1:0]          out_slot,
  output logic [ostp_pkg::STATUS_W-1:0]       out_status,
  output logic                                out_expired
);

  // Only one command token is in the chain at a time. It enters the entry
  // register, then passes one slot cell per cycle; each cell updates its own
  // slot and the token's result fields. The token leaving the last cell is
  // the finished result.

  logic                               in_xfer;
  logic                               busy_r, busy_nxt;
  ostp_pkg::token_t                   entry_r, entry_nxt;
  ostp_pkg::token_t                   tok [0:ostp_pkg::TIMER_COUNT];
  logic [ostp_pkg::TIMER_COUNT:0]     tok_valid;
  logic                               fin;
  ostp_pkg::result_t                  fin_res;
  logic                               out_v_r, out_v_nxt;
  ostp_pkg::result_t                  out_r, out_nxt;
  logic                               hold_v_r, hold_v_nxt;
  ostp_pkg::result_t                  hold_r, hold_nxt;

  // A new command is taken once the previous token has left the chain and the
  // overflow entry of the output buffer is free, so its result always has room.
  assign in_ready = !busy_r && !hold_v_r;
  assign in_xfer  = in_valid && in_ready;

  // Seed the token with the answer it gives if no cell claims it.
  always_comb begin
    entry_nxt         = entry_r;
    entry_nxt.valid   = in_xfer;
    entry_nxt.cmd     = in_command;
    entry_nxt.idx     = in_timer_index;
    entry_nxt.period  = in_period;
    entry_nxt.found   = 1'b0;
    entry_nxt.slot    = in_timer_index;
    entry_nxt.expired = 1'b0;
    unique case (in_command) inside
      ostp_pkg::CMD_REGISTER: begin
        entry_nxt.slot   = '0;
        entry_nxt.status = ostp_pkg::ST_FULL;
      end
      ostp_pkg::CMD_START, ostp_pkg::CMD_STOP,
      ostp_pkg::CMD_UNREGISTER, ostp_pkg::CMD_CHECK: begin
        entry_nxt.status = ostp_pkg::ST_UNREG;
      end
      default: begin
        entry_nxt.status = ostp_pkg::ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

  assign tok[0] = entry_r;

  for (genvar i = 0; i < ostp_pkg::TIMER_COUNT; i++) begin : g_cell
    ostp_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cell_id (ostp_pkg::ID_W'(i)),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  for (genvar i = 0; i <= ostp_pkg::TIMER_COUNT; i++) begin : g_valid
    assign tok_valid[i] = tok[i].valid;
  end

  assign fin             = tok[ostp_pkg::TIMER_COUNT].valid;
  assign fin_res.slot    = tok[ostp_pkg::TIMER_COUNT].slot;
  assign fin_res.status  = tok[ostp_pkg::TIMER_COUNT].status;
  assign fin_res.expired = tok[ostp_pkg::TIMER_COUNT].expired;

  // The chain is busy from the input transfer until the token leaves the last cell.
  always_comb begin
    busy_nxt = busy_r;
    if (in_xfer) begin
      busy_nxt = 1'b1;
    end else if (fin) begin
      busy_nxt = 1'b0;
    end
  end

  // Output register plus one overflow entry. A finished result goes straight
  // to the output register when it is free or draining; otherwise it waits in
  // the overflow entry.
  always_comb begin
    out_v_nxt  = out_v_r;
    out_nxt    = out_r;
    hold_v_nxt = hold_v_r;
    hold_nxt   = hold_r;
    if (!out_v_r || out_ready) begin
      if (hold_v_r) begin
        out_nxt    = hold_r;
        out_v_nxt  = 1'b1;
        hold_v_nxt = 1'b0;
      end else if (fin) begin
        out_nxt   = fin_res;
        out_v_nxt = 1'b1;
      end else begin
        out_v_nxt = 1'b0;
      end
    end else if (fin) begin
      hold_nxt   = fin_res;
      hold_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      out_v_r  <= 1'b0;
      hold_v_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      out_v_r  <= out_v_nxt;
      hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    hold_r <= hold_nxt;
  end

  assign out_valid   = out_v_r;
  assign out_slot    = out_r.slot;
  assign out_status  = out_r.status;
  assign out_expired = out_r.expired;

  `OSTP_ASSERT_NOW(a_single_token, 1'b1, $onehot0(tok_valid), "more than one token in the chain")
  `OSTP_ASSERT_NOW(a_fin_when_busy, fin, busy_r && !hold_v_r, "token finished while idle")
  `OSTP_ASSERT_NEXT(a_xfer_enters, in_xfer, tok_valid[0] && busy_r, "item did not enter the chain")
  `OSTP_ASSERT_NOW(a_hold_behind_out, hold_v_r, out_v_r, "overflow entry full, output empty")

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the one-shot timer pool with a scoreboard of results.
module testbench;

  // Commands 6 and 7 are not defined by the pool and must be answered as no-ops.
  localparam logic [ostp_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [ostp_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  // Receiver behaviors, one picked at random for each stretch of cycles.
  localparam int RX_EAGER  = 0;
  localparam int RX_COIN   = 1;
  localparam int RX_SPARSE = 2;
  localparam int RX_MOSTLY = 3;

  localparam int RANDOM_CMDS = 1600;
  // The long receiver hold-off begins once this many commands have gone in.
  localparam int HOLD_AFTER  = 300;
  localparam int HOLD_CYCLES = 400;

  // One pending command. A set wait_idle bit makes the sender hold the command
  // back until every result of earlier commands has been transferred.
  typedef struct packed {
    logic                          wait_idle;
    logic [ostp_pkg::CMD_W-1:0]    cmd;
    logic [ostp_pkg::IDX_W-1:0]    idx;
    logic [ostp_pkg::PERIOD_W-1:0] period;
  } timer_cmd_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [ostp_pkg::CMD_W-1:0]    in_command = '0;
  logic [ostp_pkg::IDX_W-1:0]    in_timer_index = '0;
  logic [ostp_pkg::PERIOD_W-1:0] in_period = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [ostp_pkg::IDX_W-1:0]    out_slot;
  logic [ostp_pkg::STATUS_W-1:0] out_status;
  logic                          out_expired;

  one_shot_timer_pool_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_timer_index (in_timer_index),
    .in_period      (in_period),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_slot       (out_slot),
    .out_status     (out_status),
    .out_expired    (out_expired)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Commands waiting to be offered, and results predicted but not yet seen.
  timer_cmd_t        cmd_backlog[$];
  ostp_pkg::result_t pending_outcomes[$];

  // Transfer counts. Both are updated with nonblocking assignments so that
  // every process reading them sees the values from before the clock edge.
  int cmds_taken = 0;
  int results_seen = 0;
  int err_count = 0;

  // Shadow of the pool as the predictor sees it.
  logic                          tmr_used[ostp_pkg::TIMER_COUNT];
  logic                          tmr_running[ostp_pkg::TIMER_COUNT];
  logic [ostp_pkg::PERIOD_W-1:0] tmr_period[ostp_pkg::TIMER_COUNT];
  logic [ostp_pkg::PERIOD_W-1:0] tmr_count[ostp_pkg::TIMER_COUNT];

  // Slot ownership as the stimulus generator tracks it. Allocation depends on the
  // command order alone, so this lets random commands aim at live timers.
  logic gen_used[ostp_pkg::ALLOC_LIMIT];

  // Sender pacing and receiver stall state.
  int   burst_left;
  int   gap_left;
  int   rx_mode;
  int   rx_left;
  int   rx_phase;
  int   hold_left;
  logic hold_done;
  logic hold_off = 1'b0;

  // Applies one command to the shadow pool and returns the result it must produce.
  function automatic ostp_pkg::result_t predict_outcome(
      input logic [ostp_pkg::CMD_W-1:0]    cmd,
      input logic [ostp_pkg::IDX_W-1:0]    idx,
      input logic [ostp_pkg::PERIOD_W-1:0] period);
    ostp_pkg::result_t outcome;
    logic              found;
    int                claim;
    outcome.slot    = idx;
    outcome.status  = ostp_pkg::ST_DONE;
    outcome.expired = 1'b0;
    found = 1'b0;
    claim = 0;
    case (cmd)
      ostp_pkg::CMD_TICK: begin
        // Every running timer counts up, holding at the all-ones value.
        for (int s = 0; s < ostp_pkg::TIMER_COUNT; s++)
          if (tmr_running[s] && tmr_count[s] != '1) tmr_count[s] = tmr_count[s] + 1;
      end
      ostp_pkg::CMD_REGISTER: begin
        for (int s = 0; s < ostp_pkg::ALLOC_LIMIT; s++)
          if (!found && !tmr_used[s]) begin
            found = 1'b1;
            claim = s;
          end
        if (found) begin
          tmr_used[claim]    = 1'b1;
          tmr_running[claim] = 1'b0;
          tmr_period[claim]  = period;
          tmr_count[claim]   = '0;
          outcome.slot       = claim[ostp_pkg::IDX_W-1:0];
        end else begin
          // Pool full: slot field reads zero and nothing changes.
          outcome.slot   = '0;
          outcome.status = ostp_pkg::ST_FULL;
        end
      end
      ostp_pkg::CMD_START, ostp_pkg::CMD_STOP, ostp_pkg::CMD_UNREGISTER,
      ostp_pkg::CMD_CHECK: begin
        if (idx >= ostp_pkg::TIMER_COUNT || !tmr_used[idx]) begin
          outcome.status = ostp_pkg::ST_UNREG;
        end else if (cmd == ostp_pkg::CMD_START) begin
          tmr_count[idx]   = '0;
          tmr_running[idx] = 1'b1;
        end else if (cmd == ostp_pkg::CMD_STOP) begin
          tmr_running[idx] = 1'b0;
        end else if (cmd == ostp_pkg::CMD_UNREGISTER) begin
          tmr_used[idx]    = 1'b0;
          tmr_running[idx] = 1'b0;
        end else if (tmr_running[idx] && tmr_count[idx] >= tmr_period[idx]) begin
          // A one-shot timer fires once and then stays stopped.
          tmr_running[idx] = 1'b0;
          outcome.expired  = 1'b1;
        end
      end
      default: begin
      end
    endcase
    return outcome;
  endfunction

  // Only the first ten problems are printed; the rest are just counted.
  task automatic flag_error(input string what, input logic [31:0] want, input logic [31:0] got);
    if (err_count < 10) $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    err_count++;
  endtask

  // Queues one command and keeps the generator's view of slot ownership current.
  task automatic push_cmd(input logic [ostp_pkg::CMD_W-1:0] cmd,
                          input logic [ostp_pkg::IDX_W-1:0] idx,
                          input logic [ostp_pkg::PERIOD_W-1:0] period,
                          input logic wait_idle);
    timer_cmd_t item;
    logic       claimed;
    item.wait_idle = wait_idle;
    item.cmd       = cmd;
    item.idx       = idx;
    item.period    = period;
    cmd_backlog.push_back(item);
    claimed = 1'b0;
    if (cmd == ostp_pkg::CMD_REGISTER) begin
      for (int s = 0; s < ostp_pkg::ALLOC_LIMIT; s++)
        if (!claimed && !gen_used[s]) begin
          gen_used[s] = 1'b1;
          claimed = 1'b1;
        end
    end else if (cmd == ostp_pkg::CMD_UNREGISTER && idx < ostp_pkg::ALLOC_LIMIT) begin
      gen_used[idx] = 1'b0;
    end
  endtask

  // Sender: offers commands from the backlog in bursts separated by random gaps.
  // Each accepted transfer is run through the predictor on the spot, so the
  // expectation exists before the result can possibly appear.
  always @(posedge clk) begin : sender
    timer_cmd_t nxt;
    logic       offer;
    logic       drained;
    if (!rst_n) begin
      in_valid <= 1'b0;
      for (int s = 0; s < ostp_pkg::TIMER_COUNT; s++) begin
        tmr_used[s]    = 1'b0;
        tmr_running[s] = 1'b0;
      end
      burst_left = 0;
      gap_left   = 0;
    end else begin
      drained = (cmds_taken == results_seen);
      if (in_valid && in_ready) begin
        pending_outcomes.push_back(predict_outcome(in_command, in_timer_index, in_period));
        cmds_taken <= cmds_taken + 1;
        drained = 1'b0;
      end
      // A held command stays on the bus untouched until it is taken.
      if (!in_valid || in_ready) begin
        offer = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_backlog.size() > 0 && (!cmd_backlog[0].wait_idle || drained)) begin
          nxt = cmd_backlog.pop_front();
          in_command     <= nxt.cmd;
          in_timer_index <= nxt.idx;
          in_period      <= nxt.period;
          offer = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // Mostly short bursts, now and then a long unbroken run.
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 10);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
        in_valid <= offer;
      end
    end
  end

  // Long receiver hold-off, timed in its own process. The sender keeps going,
  // so the pool's chain and output buffer fill and in_ready must drop.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_off  <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      hold_off <= (hold_left > 0);
    end else if (!hold_done && cmds_taken >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      hold_off <= 1'b1;
    end
  end

  // Monitor: checks every result transfer against the oldest prediction and
  // drives out_ready from a stall pattern that is picked anew at random now and then.
  always @(posedge clk) begin : monitor
    ostp_pkg::result_t want;
    logic              rdy;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_mode  = RX_EAGER;
      rx_left  = 0;
      rx_phase = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (pending_outcomes.size() == 0) begin
          flag_error("slot of a transfer nobody asked for", 32'd0, 32'(out_slot));
        end else begin
          want = pending_outcomes.pop_front();
          if (out_slot !== want.slot)
            flag_error("slot", 32'(want.slot), 32'(out_slot));
          if (out_status !== want.status)
            flag_error("status", 32'(want.status), 32'(out_status));
          if (out_expired !== want.expired)
            flag_error("expired", 32'(want.expired), 32'(out_expired));
        end
      end
      if (rx_left == 0) begin
        rx_mode = $urandom_range(RX_EAGER, RX_MOSTLY);
        rx_left = $urandom_range(20, 80);
      end else begin
        rx_left--;
      end
      rx_phase++;
      case (rx_mode)
        RX_EAGER:  rdy = 1'b1;
        RX_COIN:   rdy = 1'($urandom_range(0, 1));
        RX_SPARSE: rdy = (rx_phase % 4 == 0);
        default:   rdy = ($urandom_range(0, 7) != 0);
      endcase
      out_ready <= rdy && !hold_off;
    end
  end

  initial begin : stimulus
    int                            roll;
    int                            n_live;
    int                            live[ostp_pkg::ALLOC_LIMIT];
    int                            n_total;
    logic [ostp_pkg::CMD_W-1:0]    cmd;
    logic [ostp_pkg::IDX_W-1:0]    idx;
    logic [ostp_pkg::PERIOD_W-1:0] period;

    for (int s = 0; s < ostp_pkg::ALLOC_LIMIT; s++) gen_used[s] = 1'b0;

    // Fill the pool: zero period in slot 0, all-ones period in slot 1, then the rest.
    push_cmd(ostp_pkg::CMD_REGISTER, 3'd7, 32'h0000_0000, 1'b0);
    push_cmd(ostp_pkg::CMD_REGISTER, 3'd0, 32'hFFFF_FFFF, 1'b0);
    for (int s = 2; s < ostp_pkg::ALLOC_LIMIT; s++)
      push_cmd(ostp_pkg::CMD_REGISTER, ostp_pkg::IDX_W'(s), ostp_pkg::PERIOD_W'(s), 1'b0);
    // Pool full: the register is refused.
    push_cmd(ostp_pkg::CMD_REGISTER, 3'd5, 32'hA5A5_5A5A, 1'b0);
    // A zero-period timer expires at its first check, then stays stopped.
    push_cmd(ostp_pkg::CMD_START, 3'd0, 32'h0, 1'b0);
    push_cmd(ostp_pkg::CMD_CHECK, 3'd0, 32'h0, 1'b0);
    push_cmd(ostp_pkg::CMD_CHECK, 3'd0, 32'h0, 1'b0);
    // A huge period does not expire after one tick.
    push_cmd(ostp_pkg::CMD_START, 3'd1, 32'h0, 1'b0);
    push_cmd(ostp_pkg::CMD_TICK, 3'd6, 32'hFFFF_FFFF, 1'b0);
    push_cmd(ostp_pkg::CMD_CHECK, 3'd1, 32'h0, 1'b0);
    push_cmd(ostp_pkg::CMD_STOP, 3'd1, 32'h0, 1'b0);
    push_cmd(ostp_pkg::CMD_UNREGISTER, 3'd1, 32'h0, 1'b0);
    // Every slot command on a freed slot is ignored and flagged.
    push_cmd(ostp_pkg::CMD_START, 3'd1, 32'h0, 1'b0);
    push_cmd(ostp_pkg::CMD_STOP, 3'd1, 32'h0, 1'b0);
    push_cmd(ostp_pkg::CMD_CHECK, 3'd1, 32'h0, 1'b0);
    push_cmd(ostp_pkg::CMD_UNREGISTER, 3'd1, 32'h0, 1'b0);
    // Undefined commands are answered as no-ops.
    push_cmd(CMD_SPARE_LO, 3'd5, 32'h1234_5678, 1'b0);
    push_cmd(CMD_SPARE_HI, 3'd7, 32'hFFFF_FFFF, 1'b0);
    // The freed slot is the lowest free one and is claimed again.
    push_cmd(ostp_pkg::CMD_REGISTER, 3'd4, 32'd3, 1'b0);
    push_cmd(ostp_pkg::CMD_TICK, 3'd3, 32'h0, 1'b0);

    // Random part. Slot commands mostly hit live timers, periods are mostly
    // short so that ticks make timers expire, and every few hundred commands
    // the sender waits for the pool to drain completely.
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 34)      cmd = ostp_pkg::CMD_TICK;
      else if (roll < 46) cmd = ostp_pkg::CMD_REGISTER;
      else if (roll < 58) cmd = ostp_pkg::CMD_START;
      else if (roll < 64) cmd = ostp_pkg::CMD_STOP;
      else if (roll < 72) cmd = ostp_pkg::CMD_UNREGISTER;
      else if (roll < 95) cmd = ostp_pkg::CMD_CHECK;
      else                cmd = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;

      n_live = 0;
      for (int s = 0; s < ostp_pkg::ALLOC_LIMIT; s++)
        if (gen_used[s]) begin
          live[n_live] = s;
          n_live++;
        end
      if (n_live > 0 && $urandom_range(0, 9) < 8)
        idx = ostp_pkg::IDX_W'(live[$urandom_range(0, n_live - 1)]);
      else
        idx = ostp_pkg::IDX_W'($urandom_range(0, 7));

      case ($urandom_range(0, 9))
        0:       period = '0;
        1:       period = '1;
        2:       period = $urandom;
        default: period = $urandom_range(0, 12);
      endcase
      push_cmd(cmd, idx, period, (n % 500 == 499));
    end
    n_total = cmd_backlog.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (!(cmds_taken == n_total && results_seen == n_total)) @(posedge clk);
    // Keep clocking after the last result, so a stray extra result would still be caught.
    repeat (30) @(posedge clk);
    if (err_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #800000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/ostp_pkg.sv
hw/rtl/ostp_cell.sv
hw/rtl/one_shot_timer_pool_core.sv
tb/sv/testbench.sv
